### design/integer_group_aggregator_defines.svh
// Assertion macros for the integer group aggregator.
// Included by the top level; relies on clk and rst at the point of use.
`ifndef INTEGER_GROUP_AGGREGATOR_DEFINES_SVH
`define INTEGER_GROUP_AGGREGATOR_DEFINES_SVH

`ifndef SYNTH
// Condition must hold at every clock edge outside reset.
`define IGA_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Antecedent implies consequent in the same cycle.
`define IGA_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define IGA_ASSERT_ALWAYS(lbl, cond, msg)
`define IGA_ASSERT_IMPLIES(lbl, ante, cons, msg)
`endif

`endif

### design/iga_pkg.sv
// Shared types, constants and helper functions for the integer group aggregator.
// No dependencies; used by every module of the block.
package iga_pkg;

  // Accumulator width for sum and average (valid range 72 to 128).
  localparam int ACC_BITS = 128;
  // Counts saturate at 2^63-1, so 63 bits hold them.
  localparam int CNT_BITS = 63;
  localparam int DIV_CW   = $clog2(ACC_BITS);

  // Queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Aggregate function codes.
  localparam logic [2:0] FN_COUNT_ROWS = 3'd0;
  localparam logic [2:0] FN_COUNT_NN   = 3'd1;
  localparam logic [2:0] FN_SUM        = 3'd2;
  localparam logic [2:0] FN_AVG        = 3'd3;
  localparam logic [2:0] FN_MAX        = 3'd4;
  localparam logic [2:0] FN_MIN        = 3'd5;

  // Value width codes.
  localparam logic [1:0] WC_8  = 2'd0;
  localparam logic [1:0] WC_16 = 2'd1;
  localparam logic [1:0] WC_32 = 2'd2;
  localparam logic [1:0] WC_64 = 2'd3;

  // Register indexes on the configuration port.
  localparam logic REG_FUNCTION = 1'b0;
  localparam logic REG_WIDTH    = 1'b1;

  // One finished group, handed from the front to the back.
  typedef struct packed {
    logic [2:0]          func;
    logic [1:0]          wcode;
    logic [ACC_BITS-1:0] acc;
    logic [CNT_BITS-1:0] cnt;
    logic [63:0]         ext;
    logic                ext_valid;
  } job_t;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_FINISH
  } back_state_t;

  // Sign-extend the low bits selected by a width code to 64 bits.
  function automatic logic [63:0] sext64(input logic [63:0] v, input logic [1:0] wcode);
    logic [63:0] r;
    case (wcode)
      WC_8:    r = {{56{v[7]}}, v[7:0]};
      WC_16:   r = {{48{v[15]}}, v[15:0]};
      WC_32:   r = {{32{v[31]}}, v[31:0]};
      default: r = v;
    endcase
    return r;
  endfunction

endpackage

### design/integer_group_aggregator.sv
// Top level of the integer group aggregator: configuration registers,
// front end, group queue and back end. Depends on iga_pkg and the defines header.
//
//   Port group  Direction  Carries
//   s_*         in         one row: value, value_null, group_last
//   m_*         out        one result per group: agg_result, result_null, sum_overflow
//   p*          in/out     configuration registers agg_function, value_width_code
//
// The front end takes one row per cycle while the queue is not full and updates the
// running state in that cycle. A group result loads straight into the output register,
// or, for an average over a nonzero count, after the one-bit-per-cycle divider.
// The queue holds two finished groups; rows stall only while it is full.
// Reset is synchronous and clears the running state, the queue and the output register.
`include "integer_group_aggregator_defines.svh"

module integer_group_aggregator (
  input  logic        clk,
  input  logic        rst,
  // Row stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [63:0] value
  input  logic        s_tuser,   // [0] value_null
  input  logic        s_tlast,
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [63:0] agg_result
  output logic [1:0]  m_tuser,   // [0] result_null, [1] sum_overflow
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [2:0]    agg_function;
  logic [1:0]    value_width_code;
  logic          cfg_wr;
  logic          q_push, q_pop, q_full, q_empty;
  iga_pkg::job_t q_wdata, q_rdata;

  // Register writes complete on the access cycle.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      agg_function     <= iga_pkg::FN_COUNT_ROWS;
      value_width_code <= iga_pkg::WC_64;
    end else if (cfg_wr) begin
      if (paddr[2] == iga_pkg::REG_FUNCTION) begin
        agg_function <= pwdata[2:0];
      end else begin
        value_width_code <= pwdata[1:0];
      end
    end
  end

  assign prdata = (paddr[2] == iga_pkg::REG_WIDTH) ? {30'd0, value_width_code}
                                                   : {29'd0, agg_function};

  iga_front u_front (
    .clk              (clk),
    .rst              (rst),
    .s_tvalid         (s_tvalid),
    .s_tready         (s_tready),
    .s_tdata          (s_tdata),
    .s_tuser          (s_tuser),
    .s_tlast          (s_tlast),
    .agg_function     (agg_function),
    .value_width_code (value_width_code),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_data           (q_wdata)
  );

  iga_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  iga_back u_back (
    .clk      (clk),
    .rst      (rst),
    .job      (q_rdata),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // A group is never pushed into a full queue, nor popped from an empty one.
  `IGA_ASSERT_IMPLIES(a_no_push_full, q_push, !q_full, "group pushed into full queue")
  `IGA_ASSERT_IMPLIES(a_no_pop_empty, q_pop, !q_empty, "group popped from empty queue")
  // A result is never both null and overflowed.
  `IGA_ASSERT_ALWAYS(a_flags_exclusive, !(m_tvalid && m_tuser[0] && m_tuser[1]),
                     "result_null and sum_overflow both set")

endmodule

### design/iga_front.sv
// Front end: accepts rows and folds them into count, sum and extreme state.
// Depends on iga_pkg; hands each finished group to the queue as a job_t.
module iga_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [63:0]         s_tdata,   // [63:0] value
  input  logic                s_tuser,   // [0] value_null
  input  logic                s_tlast,
  input  logic [2:0]          agg_function,
  input  logic [1:0]          value_width_code,
  input  logic                q_full,
  output logic                q_push,
  output iga_pkg::job_t       q_data
);

  logic [iga_pkg::ACC_BITS-1:0] acc, acc_next, acc_upd;
  logic [iga_pkg::CNT_BITS-1:0] cnt, cnt_next, cnt_upd;
  logic [63:0]                  ext, ext_next, ext_upd;
  logic                         ext_valid, ext_valid_next, ext_valid_upd;
  logic [63:0]                  v;
  logic                         take;
  logic                         cnt_inc;
  logic                         better;

  // A row is refused only while the queue cannot take a finished group.
  assign s_tready = !q_full;
  assign take     = s_tvalid && s_tready;

  assign v = iga_pkg::sext64(s_tdata, value_width_code);

  // Fold the row into the running state.
  always_comb begin
    cnt_inc = (agg_function == iga_pkg::FN_COUNT_ROWS) || !s_tuser;
    cnt_upd = cnt;
    if (cnt_inc && (cnt != {iga_pkg::CNT_BITS{1'b1}})) begin
      cnt_upd = cnt + 1'b1;
    end
    if (agg_function == iga_pkg::FN_MIN) begin
      better = $signed(v) < $signed(ext);
    end else begin
      better = $signed(v) > $signed(ext);
    end
    acc_upd       = acc;
    ext_upd       = ext;
    ext_valid_upd = ext_valid;
    if (!s_tuser) begin
      acc_upd       = acc + {{(iga_pkg::ACC_BITS-64){v[63]}}, v};
      ext_valid_upd = 1'b1;
      if (!ext_valid || better) begin
        ext_upd = v;
      end
    end
  end

  // State clears after the last row of a group.
  always_comb begin
    acc_next       = acc;
    cnt_next       = cnt;
    ext_next       = ext;
    ext_valid_next = ext_valid;
    if (take) begin
      if (s_tlast) begin
        acc_next       = '0;
        cnt_next       = '0;
        ext_next       = '0;
        ext_valid_next = 1'b0;
      end else begin
        acc_next       = acc_upd;
        cnt_next       = cnt_upd;
        ext_next       = ext_upd;
        ext_valid_next = ext_valid_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      cnt       <= '0;
      ext       <= '0;
      ext_valid <= 1'b0;
    end else begin
      acc       <= acc_next;
      cnt       <= cnt_next;
      ext       <= ext_next;
      ext_valid <= ext_valid_next;
    end
  end

  // A finished group carries the running state with its last row folded in.
  assign q_push           = take && s_tlast;
  assign q_data.func      = agg_function;
  assign q_data.wcode     = value_width_code;
  assign q_data.acc       = acc_upd;
  assign q_data.cnt       = cnt_upd;
  assign q_data.ext       = ext_upd;
  assign q_data.ext_valid = ext_valid_upd;

endmodule

### design/iga_queue.sv
// Short queue of finished groups between the front and back ends.
// Depends on iga_pkg for job_t and the queue depth.
module iga_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  iga_pkg::job_t wdata,
  input  logic          pop,
  output iga_pkg::job_t rdata,
  output logic          full,
  output logic          empty
);

  iga_pkg::job_t                 mem [iga_pkg::QUEUE_DEPTH];
  logic [iga_pkg::QUEUE_AW-1:0]  wptr, rptr;
  logic [iga_pkg::QUEUE_AW:0]    fill;

  assign full  = (fill == (iga_pkg::QUEUE_AW+1)'(iga_pkg::QUEUE_DEPTH));
  assign empty = (fill == '0);
  assign rdata = mem[rptr];

  // Storage holds payload only.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

### design/iga_back.sv
// Back end: turns a finished group into a result, with a bit-serial divider
// for the average, and holds the result in the output register.
// Depends on iga_pkg.
module iga_back (
  input  logic          clk,
  input  logic          rst,
  input  iga_pkg::job_t job,
  input  logic          q_empty,
  output logic          q_pop,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [63:0]   m_tdata,   // [63:0] agg_result
  output logic [1:0]    m_tuser    // [0] result_null, [1] sum_overflow
);

  iga_pkg::back_state_t state, state_next;

  // Divider registers.
  logic [iga_pkg::ACC_BITS-1:0] dvd;
  logic [iga_pkg::CNT_BITS-1:0] dsr;
  logic [iga_pkg::CNT_BITS-1:0] rem;
  logic [63:0]                  quo;
  logic                         neg;
  logic [1:0]                   div_wcode;
  logic [iga_pkg::DIV_CW-1:0]   step;

  // Output register.
  logic [63:0] out_data;
  logic        out_null;
  logic        out_ovf;
  logic        out_valid;

  logic                         out_free;
  logic                         is_div;
  logic                         div_load;
  logic                         res_load;
  logic                         from_div;
  logic [iga_pkg::CNT_BITS:0]   trial;
  logic                         fits_q;
  logic [iga_pkg::ACC_BITS-1:0] mag;
  logic [63:0]                  sum_r;
  logic                         sum_fits;
  logic [63:0]                  direct_data;
  logic                         direct_null;
  logic                         direct_ovf;
  logic [63:0]                  quo_signed;

  assign out_free = !out_valid || m_tready;
  assign is_div   = (job.func == iga_pkg::FN_AVG) && (job.cnt != '0);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      iga_pkg::BK_IDLE: begin
        if (!q_empty && out_free && is_div) begin
          state_next = iga_pkg::BK_DIV;
        end
      end
      iga_pkg::BK_DIV: begin
        if (step == iga_pkg::DIV_CW'(iga_pkg::ACC_BITS - 1)) begin
          state_next = iga_pkg::BK_FINISH;
        end
      end
      iga_pkg::BK_FINISH: begin
        if (out_free) begin
          state_next = iga_pkg::BK_IDLE;
        end
      end
      default: state_next = iga_pkg::BK_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    q_pop    = 1'b0;
    div_load = 1'b0;
    res_load = 1'b0;
    from_div = 1'b0;
    case (state)
      iga_pkg::BK_IDLE: begin
        q_pop    = !q_empty && out_free;
        div_load = q_pop && is_div;
        res_load = q_pop && !is_div;
      end
      iga_pkg::BK_FINISH: begin
        res_load = out_free;
        from_div = 1'b1;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iga_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Results that need no division.
  always_comb begin
    sum_r       = iga_pkg::sext64(job.acc[63:0], job.wcode);
    sum_fits    = (job.acc == {{(iga_pkg::ACC_BITS-64){sum_r[63]}}, sum_r});
    direct_data = '0;
    direct_null = 1'b0;
    direct_ovf  = 1'b0;
    case (job.func)
      iga_pkg::FN_COUNT_ROWS,
      iga_pkg::FN_COUNT_NN: direct_data = {1'b0, job.cnt};
      iga_pkg::FN_SUM: begin
        if (sum_fits) begin
          direct_data = sum_r;
        end else begin
          direct_ovf = 1'b1;
        end
      end
      iga_pkg::FN_MAX,
      iga_pkg::FN_MIN: begin
        if (job.ext_valid) begin
          direct_data = iga_pkg::sext64(job.ext, job.wcode);
        end else begin
          direct_null = 1'b1;
        end
      end
      default: direct_data = '0;
    endcase
  end

  // Divider: magnitude of the sum over the count, one quotient bit a cycle.
  assign mag        = job.acc[iga_pkg::ACC_BITS-1] ? (~job.acc + 1'b1) : job.acc;
  assign trial      = {rem, dvd[iga_pkg::ACC_BITS-1]};
  assign fits_q     = (trial >= {1'b0, dsr});
  assign quo_signed = neg ? (~quo + 1'b1) : quo;

  always_ff @(posedge clk) begin
    if (div_load) begin
      dvd       <= mag;
      dsr       <= job.cnt;
      rem       <= '0;
      quo       <= '0;
      neg       <= job.acc[iga_pkg::ACC_BITS-1];
      div_wcode <= job.wcode;
      step      <= '0;
    end else if (state == iga_pkg::BK_DIV) begin
      dvd  <= {dvd[iga_pkg::ACC_BITS-2:0], 1'b0};
      step <= step + 1'b1;
      if (fits_q) begin
        rem <= iga_pkg::CNT_BITS'(trial - {1'b0, dsr});
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= trial[iga_pkg::CNT_BITS-1:0];
        quo <= {quo[62:0], 1'b0};
      end
    end
  end

  // Output register; a new result loads as the old one leaves.
  always_ff @(posedge clk) begin
    if (res_load) begin
      if (from_div) begin
        out_data <= iga_pkg::sext64(quo_signed, div_wcode);
        out_null <= 1'b0;
        out_ovf  <= 1'b0;
      end else begin
        out_data <= direct_data;
        out_null <= direct_null;
        out_ovf  <= direct_ovf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tuser  = {out_ovf, out_null};

endmodule

### bench/integer_group_aggregator_tb.sv
// Self-checking testbench for integer_group_aggregator: row stream in, one result per group out.
// Holds its own model of the aggregate state and drives rows and APB writes from plain tasks.
// Depends on iga_pkg and the design files only.
`timescale 1ns / 1ps

// One expected group result.
typedef struct packed {
  logic [63:0] res;
  logic        rnull;
  logic        ovf;
} agg_result_t;

// Running aggregate of the current group and the queue of results still awaited.
class aggregate_scoreboard;
  logic [2:0]          func;
  logic [1:0]          wcode;
  logic signed [127:0] sum_acc;
  logic [62:0]         row_cnt;
  logic signed [63:0]  extreme;
  bit                  extreme_ok;
  agg_result_t         awaited[$];
  int                  mismatches;

  function new();
    func       = iga_pkg::FN_COUNT_ROWS;
    wcode      = iga_pkg::WC_64;
    mismatches = 0;
    clear_group();
  endfunction

  function void clear_group();
    sum_acc    = '0;
    row_cnt    = '0;
    extreme    = '0;
    extreme_ok = 1'b0;
  endfunction

  // Keep the low 8, 16, 32 or 64 bits and sign-extend them.
  function logic [63:0] narrow(logic [63:0] v, logic [1:0] wc);
    logic signed [63:0] t;
    int unsigned sh;
    sh = 64 - (8 << wc);
    t  = v << sh;
    return t >>> sh;
  endfunction

  // Fold one accepted row into the group; on the group's last row, queue its result.
  function void fold_row(logic [63:0] raw, logic is_null, logic last);
    logic signed [63:0]  v;
    logic signed [63:0]  narrowed;
    logic signed [127:0] quot;
    agg_result_t         r;
    v = narrow(raw, wcode);
    if ((func == iga_pkg::FN_COUNT_ROWS || !is_null) && row_cnt != '1)
      row_cnt = row_cnt + 1'b1;
    if (!is_null) begin
      sum_acc = sum_acc + {{64{v[63]}}, v};
      // The extreme is a minimum only while the min function is selected.
      if (!extreme_ok || (func == iga_pkg::FN_MIN ? (v < extreme) : (v > extreme)))
        extreme = v;
      extreme_ok = 1'b1;
    end
    if (!last)
      return;
    r = '0;
    case (func)
      iga_pkg::FN_COUNT_ROWS, iga_pkg::FN_COUNT_NN: r.res = {1'b0, row_cnt};
      iga_pkg::FN_SUM: begin
        narrowed = narrow(sum_acc[63:0], wcode);
        if (sum_acc == {{64{narrowed[63]}}, narrowed})
          r.res = narrowed;
        else
          r.ovf = 1'b1;
      end
      iga_pkg::FN_AVG: begin
        if (row_cnt != '0) begin
          quot  = sum_acc / $signed({65'd0, row_cnt});
          r.res = narrow(quot[63:0], wcode);
        end
      end
      iga_pkg::FN_MAX, iga_pkg::FN_MIN: begin
        if (extreme_ok)
          r.res = narrow(extreme, wcode);
        else
          r.rnull = 1'b1;
      end
      default: ;
    endcase
    awaited.push_back(r);
    clear_group();
  endfunction

  // Compare one accepted result transaction with the oldest expectation.
  function void check_result(logic [63:0] data, logic [1:0] user);
    agg_result_t e;
    if (awaited.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: data=%h user=%b", data, user);
      return;
    end
    e = awaited.pop_front();
    if (e.res !== data || e.rnull !== user[0] || e.ovf !== user[1]) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected res=%h null=%b ovf=%b, got res=%h null=%b ovf=%b",
                 e.res, e.rnull, e.ovf, data, user[0], user[1]);
    end
  endfunction
endclass

module integer_group_aggregator_tb;

  localparam logic [2:0]  ADDR_FUNCTION = {iga_pkg::REG_FUNCTION, 2'b00};
  localparam logic [2:0]  ADDR_WIDTH    = {iga_pkg::REG_WIDTH, 2'b00};
  localparam logic [63:0] MAX64         = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MIN64         = 64'h8000_0000_0000_0000;
  // Longest back-end run is an average division; leave margin beyond it.
  localparam int          SETTLE_CYCLES = 200;
  localparam int          IDLE_LIMIT    = 4000;
  localparam int          PHASES        = 12;
  localparam int          PHASE_ROWS    = 64;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata  = '0;
  logic        s_tuser  = 1'b0;
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  aggregate_scoreboard sb = new();

  int burst_left = 0;
  int rx_left    = 0;
  bit rx_on      = 1'b1;
  int idle_cnt   = 0;

  integer_group_aggregator DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver: ready and stall stretches of random length, long ready runs more likely.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_on   = ($urandom_range(0, 2) != 0);
      rx_left = rx_on ? $urandom_range(1, 40) : $urandom_range(1, 12);
    end
    rx_left  = rx_left - 1;
    m_tready <= rx_on;
  end

  // Check every accepted result transaction.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_result(m_tdata, m_tuser);
  end

  // Watchdog on cycles in which no transaction of any kind completes.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
      idle_cnt = 0;
    else
      idle_cnt = idle_cnt + 1;
    if (idle_cnt >= IDLE_LIMIT) begin
      $display("integer_group_aggregator_tb failed");
      $finish;
    end
  end

  // Send one row; the sender works in bursts with random gaps between them.
  task automatic send_row(input logic [63:0] v, input logic is_null, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left = burst_left - 1;
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tuser  <= is_null;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    sb.fold_row(v, is_null, last);
  endtask

  // Stop the row stream and wait until the block has nothing left in flight.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready. psel is dropped by the caller.
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic apply_config(input logic [2:0] fn, input logic [1:0] wc);
    settle();
    write_reg(ADDR_FUNCTION, {29'd0, fn});
    write_reg(ADDR_WIDTH, {30'd0, wc});
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.func  = fn;
    sb.wcode = wc;
  endtask

  // Random column value: raw 64 bits, width extremes, small values or in-range values.
  function automatic logic [63:0] rand_value(input logic [1:0] wc);
    logic [63:0] r;
    logic [63:0] top;
    int unsigned sh;
    sh  = 64 - (8 << wc);
    top = MAX64 >> sh;
    r   = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0:       ;
      1:       r = top;
      2:       r = ~top;
      3:       r = 64'($signed($urandom_range(0, 8)) - 4);
      default: r = sb.narrow(r, wc);
    endcase
    return r;
  endfunction

  initial begin
    int       p;
    int       sent;
    int       glen;
    int       nmode;
    int       k;
    logic [1:0] wc;
    logic     nul;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Row count counts nulls too.
    apply_config(iga_pkg::FN_COUNT_ROWS, iga_pkg::WC_64);
    send_row(64'd0, 1'b1, 1'b0);
    send_row(MAX64, 1'b0, 1'b0);
    send_row(MIN64, 1'b0, 1'b1);

    // Non-null count, including a group of nulls only.
    apply_config(iga_pkg::FN_COUNT_NN, iga_pkg::WC_64);
    send_row(64'd5, 1'b1, 1'b0);
    send_row(64'd7, 1'b0, 1'b1);
    send_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1);

    // Sum past the 64-bit range overflows; opposite extremes cancel.
    apply_config(iga_pkg::FN_SUM, iga_pkg::WC_64);
    send_row(MAX64, 1'b0, 1'b0);
    send_row(64'd1, 1'b0, 1'b1);
    send_row(MIN64, 1'b0, 1'b0);
    send_row(MAX64, 1'b0, 1'b1);

    // Eight-bit sum: upper value bits are ignored, 128 overflows, -128 fits.
    apply_config(iga_pkg::FN_SUM, iga_pkg::WC_8);
    send_row(64'h1234_5678_9ABC_DE7F, 1'b0, 1'b0);
    send_row(64'd1, 1'b0, 1'b1);
    send_row(64'hA5A5_A5A5_A5A5_A580, 1'b0, 1'b1);

    // Average truncates toward zero; average of nothing is zero.
    apply_config(iga_pkg::FN_AVG, iga_pkg::WC_16);
    send_row(64'hFFFF_FFFF_FFFF_FFF9, 1'b0, 1'b0);
    send_row(64'd2, 1'b0, 1'b0);
    send_row(64'd100, 1'b1, 1'b1);
    send_row(64'd1, 1'b1, 1'b1);

    // Max at 32 bits, then a max with no value gives a null result.
    apply_config(iga_pkg::FN_MAX, iga_pkg::WC_32);
    send_row(64'h0000_0000_8000_0000, 1'b0, 1'b0);
    send_row(64'h0000_0000_7FFF_FFFF, 1'b0, 1'b1);
    send_row(64'd9, 1'b1, 1'b1);

    // Function changes in the middle of a group: the extreme switches from max to min.
    apply_config(iga_pkg::FN_MAX, iga_pkg::WC_64);
    send_row(64'd5, 1'b0, 1'b0);
    send_row(64'hFFFF_FFFF_FFFF_FFFD, 1'b0, 1'b0);
    apply_config(iga_pkg::FN_MIN, iga_pkg::WC_64);
    send_row(MIN64, 1'b0, 1'b0);
    send_row(64'd3, 1'b1, 1'b1);

    // Unused function codes still fold rows but return zero.
    apply_config(3'd6, iga_pkg::WC_64);
    send_row(64'd4, 1'b0, 1'b0);
    send_row(64'd9, 1'b0, 1'b1);
    apply_config(3'd7, iga_pkg::WC_8);
    send_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1);

    // Random phases cycle through every function and width; a phase may end mid-group.
    for (p = 0; p < PHASES; p++) begin
      wc = 2'(p % 4);
      apply_config(3'(p % 6), wc);
      sent = 0;
      while (sent < PHASE_ROWS) begin
        glen  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
        nmode = $urandom_range(0, 3);
        for (k = 0; k < glen; k++) begin
          nul = (nmode == 2) || (nmode != 0 && $urandom_range(0, 3) == 0);
          send_row(rand_value(wc), nul, k == glen - 1);
        end
        sent += glen;
      end
      if (p != PHASES - 1 && $urandom_range(0, 1) == 1) begin
        repeat ($urandom_range(1, 4))
          send_row(rand_value(wc), 1'($urandom_range(0, 1)), 1'b0);
      end
    end

    settle();
    if (sb.mismatches == 0 && sb.awaited.size() == 0)
      $display("integer_group_aggregator_tb passed");
    else
      $display("integer_group_aggregator_tb failed");
    $finish;
  end

endmodule
